// File: hw/rtl/vbrhp_pkg.sv
// ----------------------------------------------------------------------------
// VBR info header parser package
// Types, state codes and tag constants shared by the parser modules.
// ----------------------------------------------------------------------------
package vbrhp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_TAG    = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_FRAMES = 3'd4,
    PH_BYTES  = 3'd5,
    PH_TOC    = 3'd6,
    PH_SCALE  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_FLAGS  = 3'd1,
    KIND_FRAMES = 3'd2,
    KIND_BYTES  = 3'd3,
    KIND_TOC    = 3'd4,
    KIND_SCALE  = 3'd5
  } kind_e;

  localparam logic [1:0] LayerThree = 2'd3;
  localparam logic [5:0] SkipShort  = 6'd9;
  localparam logic [5:0] SkipMid    = 6'd17;
  localparam logic [5:0] SkipLong   = 6'd32;
  localparam int unsigned WordBytes = 4;

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
    logic [1:0] layer;
    logic       low_rate;
    logic       mono;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [6:0]  toc_index;
    logic        last;
  } result_t;

  function automatic logic [7:0] tag_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h58;
      2'd1:    c = 8'h69;
      2'd2:    c = 8'h6e;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/vbrhp_core.sv
// ----------------------------------------------------------------------------
// VBR info header parser core
// Holds the parse state and turns one byte into at most one result.
// ----------------------------------------------------------------------------
module vbrhp_core #(
  parameter int unsigned TOC_ENTRIES = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  vbrhp_pkg::item_t   item_i,
  output logic              res_valid_o,
  output vbrhp_pkg::result_t res_o
);

  localparam logic [6:0] TocLast = 7'(TOC_ENTRIES - 1);
  localparam logic [6:0] WordLen = 7'(vbrhp_pkg::WordBytes);

  vbrhp_pkg::phase_e phase_q, phase_d;
  logic [6:0]  byte_count_q, byte_count_d;
  logic [31:0] word_shift_q, word_shift_d;
  logic [3:0]  present_flags_q, present_flags_d;
  logic [5:0]  skip_length_q, skip_length_d;

  vbrhp_pkg::phase_e cur_phase;
  logic [6:0]  cur_bc;
  logic [6:0]  bc_inc;
  logic [31:0] cur_ws;
  logic [31:0] ws_new;
  logic [3:0]  cur_pf;
  logic [3:0]  pf_new;
  logic [5:0]  cur_skip;
  vbrhp_pkg::phase_e nxt;

  function automatic vbrhp_pkg::phase_e next_after(input vbrhp_pkg::phase_e ph,
                                                   input logic [3:0] pf);
    vbrhp_pkg::phase_e r;
    r = vbrhp_pkg::PH_IDLE;
    priority if (ph < vbrhp_pkg::PH_FRAMES && pf[0]) begin
      r = vbrhp_pkg::PH_FRAMES;
    end else if (ph < vbrhp_pkg::PH_BYTES && pf[1]) begin
      r = vbrhp_pkg::PH_BYTES;
    end else if (ph < vbrhp_pkg::PH_TOC && pf[2]) begin
      r = vbrhp_pkg::PH_TOC;
    end else if (ph < vbrhp_pkg::PH_SCALE && pf[3]) begin
      r = vbrhp_pkg::PH_SCALE;
    end
    return r;
  endfunction

  always_comb begin
    cur_phase = phase_q;
    cur_bc    = byte_count_q;
    cur_ws    = word_shift_q;
    cur_pf    = present_flags_q;
    cur_skip  = skip_length_q;

    phase_d         = phase_q;
    byte_count_d    = byte_count_q;
    word_shift_d    = word_shift_q;
    present_flags_d = present_flags_q;
    skip_length_d   = skip_length_q;

    res_valid_o     = 1'b0;
    res_o.kind      = vbrhp_pkg::KIND_NONE;
    res_o.value     = '0;
    res_o.toc_index = '0;
    res_o.last      = 1'b0;

    if (item_i.start_req) begin
      cur_bc = '0;
      cur_ws = '0;
      cur_pf = '0;
      if (item_i.layer != vbrhp_pkg::LayerThree) begin
        cur_phase = vbrhp_pkg::PH_IDLE;
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
      end else begin
        if (item_i.low_rate) begin
          cur_skip = item_i.mono ? vbrhp_pkg::SkipShort : vbrhp_pkg::SkipMid;
        end else begin
          cur_skip = item_i.mono ? vbrhp_pkg::SkipMid : vbrhp_pkg::SkipLong;
        end
        cur_phase = vbrhp_pkg::PH_SKIP;
      end
    end

    bc_inc = cur_bc + 7'd1;
    ws_new = {cur_ws[23:0], item_i.data_byte};
    pf_new = (cur_phase == vbrhp_pkg::PH_FLAGS) ? item_i.data_byte[3:0] : cur_pf;
    nxt    = next_after(cur_phase, pf_new);

    phase_d         = cur_phase;
    byte_count_d    = cur_bc;
    word_shift_d    = cur_ws;
    present_flags_d = cur_pf;
    skip_length_d   = cur_skip;

    unique case (cur_phase)
      vbrhp_pkg::PH_SKIP: begin
        byte_count_d = bc_inc;
        if (bc_inc >= {1'b0, cur_skip}) begin
          phase_d      = vbrhp_pkg::PH_TAG;
          byte_count_d = '0;
        end
      end
      vbrhp_pkg::PH_TAG: begin
        if (item_i.data_byte != vbrhp_pkg::tag_char(cur_bc[1:0])) begin
          phase_d      = vbrhp_pkg::PH_IDLE;
          byte_count_d = '0;
          res_valid_o  = 1'b1;
          res_o.last   = 1'b1;
        end else begin
          byte_count_d = bc_inc;
          if (bc_inc >= WordLen) begin
            phase_d      = vbrhp_pkg::PH_FLAGS;
            byte_count_d = '0;
            word_shift_d = '0;
          end
        end
      end
      vbrhp_pkg::PH_FLAGS, vbrhp_pkg::PH_FRAMES,
      vbrhp_pkg::PH_BYTES, vbrhp_pkg::PH_SCALE: begin
        word_shift_d = ws_new;
        byte_count_d = bc_inc;
        if (bc_inc >= WordLen) begin
          present_flags_d = pf_new;
          phase_d         = nxt;
          byte_count_d    = '0;
          word_shift_d    = '0;
          res_valid_o     = 1'b1;
          res_o.value     = ws_new;
          res_o.last      = (nxt == vbrhp_pkg::PH_IDLE);
          unique case (cur_phase)
            vbrhp_pkg::PH_FLAGS:  res_o.kind = vbrhp_pkg::KIND_FLAGS;
            vbrhp_pkg::PH_FRAMES: res_o.kind = vbrhp_pkg::KIND_FRAMES;
            vbrhp_pkg::PH_BYTES:  res_o.kind = vbrhp_pkg::KIND_BYTES;
            default:              res_o.kind = vbrhp_pkg::KIND_SCALE;
          endcase
        end
      end
      vbrhp_pkg::PH_TOC: begin
        byte_count_d    = bc_inc;
        res_valid_o     = 1'b1;
        res_o.kind      = vbrhp_pkg::KIND_TOC;
        res_o.value     = {24'd0, item_i.data_byte};
        res_o.toc_index = cur_bc;
        if (cur_bc >= TocLast) begin
          phase_d      = nxt;
          byte_count_d = '0;
          word_shift_d = '0;
          res_o.last   = (nxt == vbrhp_pkg::PH_IDLE);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= vbrhp_pkg::PH_IDLE;
      byte_count_q    <= '0;
      word_shift_q    <= '0;
      present_flags_q <= '0;
      skip_length_q   <= '0;
    end else if (en_i) begin
      phase_q         <= phase_d;
      byte_count_q    <= byte_count_d;
      word_shift_q    <= word_shift_d;
      present_flags_q <= present_flags_d;
      skip_length_q   <= skip_length_d;
    end
  end

`ifndef ASSERT_OFF
  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == vbrhp_pkg::PH_SKIP |-> byte_count_q < {1'b0, skip_length_q})
    else $error("skip count passed the side-info length");

  a_toc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == vbrhp_pkg::PH_TOC |-> byte_count_q <= TocLast)
    else $error("seek-table index passed the last entry");
`endif

endmodule

// File: hw/rtl/vbr_info_header_parser.sv
// ----------------------------------------------------------------------------
// VBR info header parser
// Parses the Xing information header from the bytes of one audio frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle, starting with the byte after the
// frame header, and reports the flags word, the optional counts, each seek
// table entry and the quality scale as separate items, the final one marked
// with last; a frame with no header gives a single item marked last. An item
// passes through an input register and then a result register, and one byte
// can be taken in every cycle while the output is not stalled.
module vbr_info_header_parser #(
  parameter int unsigned TOC_ENTRIES = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [7:0]  data_byte_i,
  input  logic [1:0]  layer_i,
  input  logic        low_rate_i,
  input  logic        mono_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic [6:0]  toc_index_o,
  output logic        last_o
);

  logic               s0_valid_q, s0_valid_d;
  vbrhp_pkg::item_t   s0_item_q;
  logic               out_valid_q, out_valid_d;
  vbrhp_pkg::result_t out_res_q;
  logic               res_valid;
  vbrhp_pkg::result_t res;
  logic               out_free;
  logic               advance;
  logic               accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s0_valid_q && (out_free || !res_valid);
  assign in_stall_o = s0_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  vbrhp_core #(
    .TOC_ENTRIES(TOC_ENTRIES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (s0_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (advance) begin
      s0_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_item_q.start_req <= start_req_i;
      s0_item_q.data_byte <= data_byte_i;
      s0_item_q.layer     <= layer_i;
      s0_item_q.low_rate  <= low_rate_i;
      s0_item_q.mono      <= mono_i;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_res_q.kind;
  assign value_o     = out_res_q.value;
  assign toc_index_o = out_res_q.toc_index;
  assign last_o      = out_res_q.last;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled while the result register could move");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == vbrhp_pkg::KIND_NONE |-> last_o)
    else $error("no-header item not marked last");

  a_index_only_toc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != vbrhp_pkg::KIND_TOC |-> toc_index_o == 7'd0)
    else $error("table index set on a non-table item");
`endif

endmodule
